### design/srecord_image_framer_macros.svh
// ----------------------------------------------------------------------------
// srecord_image_framer_macros
// Assertion macros used by the framer sequencer.
// ----------------------------------------------------------------------------
`ifndef SRECORD_IMAGE_FRAMER_MACROS_SVH
`define SRECORD_IMAGE_FRAMER_MACROS_SVH

// condition that must hold on every clock outside reset
`define SRIF_CHECK(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// trigger implies a condition in the same cycle
`define SRIF_IMPLY(name, trig, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// trigger implies a condition in the next cycle
`define SRIF_NEXT(name, trig, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

### design/srif_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srif_pkg
// Shared constants, codes and control structs of the S-record image framer.
// ----------------------------------------------------------------------------
package srif_pkg;

	localparam int BANK_BYTES = 8192;
	localparam int MAX_RUN    = 32;
	localparam int MAX_BANKS  = 256;

	localparam int ADDR_W = 24;
	localparam int BYTE_W = 8;
	localparam int OFS_W  = $clog2(BANK_BYTES);
	localparam int BANK_W = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
	localparam int CNT_W  = $clog2(MAX_RUN + 1);
	localparam int IDX_W  = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

	localparam logic [BYTE_W-1:0] FREE_TAG     = 8'hFF;
	localparam logic [BYTE_W-1:0] HDR_OVERHEAD = 8'd4;
	localparam int                PAGE_SHIFT   = 13;

	typedef enum logic [1:0] {
		KIND_HDR  = 2'd0,
		KIND_DATA = 2'd1,
		KIND_CHK  = 2'd2,
		KIND_TRL  = 2'd3
	} kind_t;

	typedef struct packed {
		logic capture;
		logic step;
		logic advance;
		logic emit_hdr;
		logic emit_data;
		logic emit_chk;
		logic emit_trl;
		logic rd_en;
		logic rd_first;
		logic clear_run;
	} srif_cmd_t;

	typedef struct packed {
		logic dump;
		logic last;
		logic out_free;
		logic data_end;
	} srif_sts_t;

endpackage

### design/srif_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srif_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module srif_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/srif_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srif_dp
// Framer datapath: run buffer, bank and offset counters, checksum and the
// output register.
// ----------------------------------------------------------------------------
module srif_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  srif_pkg::srif_cmd_t           cmd,
	output srif_pkg::srif_sts_t           sts,
	input  logic [srif_pkg::ADDR_W-1:0]   cfg_data,
	input  logic                          cfg_we,
	input  logic [srif_pkg::BYTE_W-1:0]   map_tag,
	input  logic [srif_pkg::BYTE_W-1:0]   data_byte,
	input  logic                          last_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    kind,
	output logic [srif_pkg::BYTE_W-1:0]   value,
	output logic [srif_pkg::ADDR_W-1:0]   address,
	output logic                          last_of_run
);
	import srif_pkg::*;

	localparam logic [ADDR_W-1:0] BANK_BYTES_A = ADDR_W'(BANK_BYTES);

	logic [ADDR_W-1:0] base_q;
	logic [BYTE_W-1:0] tag_q;
	logic [BYTE_W-1:0] data_q;
	logic              last_q;
	logic [CNT_W-1:0]  run_count_q;
	logic [OFS_W-1:0]  run_start_q;
	logic [BANK_W-1:0] bank_q;
	logic [OFS_W-1:0]  offset_q;
	logic [BYTE_W-1:0] first_tag_q;
	logic [BYTE_W-1:0] sum_q;
	logic [IDX_W-1:0]  rd_idx_q;

	logic              out_valid_q;
	kind_t             kind_q;
	logic [BYTE_W-1:0] value_q;
	logic [ADDR_W-1:0] address_q;
	logic              last_of_run_q;

	logic              used;
	logic [CNT_W-1:0]  cnt_new;
	logic              bank_end;
	logic [ADDR_W-1:0] hdr_addr;
	logic [BYTE_W-1:0] hdr_count;
	logic [BYTE_W-1:0] hdr_sum;
	logic [ADDR_W-1:0] trl_addr;
	logic [BYTE_W-1:0] trl_sum;
	logic [IDX_W-1:0]  raddr;
	logic [BYTE_W-1:0] rdata;

	function automatic logic [BYTE_W-1:0] addr_bytes(input logic [ADDR_W-1:0] a);
		addr_bytes = a[23:16] + a[15:8] + a[7:0];
	endfunction

	assign used     = (tag_q != FREE_TAG);
	assign cnt_new  = used ? run_count_q + CNT_W'(1) : run_count_q;
	assign bank_end = (offset_q == OFS_W'(BANK_BYTES - 1));

	// run start sits inside the bank, so bank base plus start never carries past it
	assign hdr_addr  = base_q + ADDR_W'(bank_q) * BANK_BYTES_A + ADDR_W'(run_start_q);
	assign hdr_count = BYTE_W'(run_count_q) + HDR_OVERHEAD;
	assign hdr_sum   = hdr_count + addr_bytes(hdr_addr);
	assign trl_addr  = ADDR_W'(first_tag_q[7:5]) << PAGE_SHIFT;
	assign trl_sum   = HDR_OVERHEAD + addr_bytes(trl_addr);

	assign raddr = cmd.rd_first ? '0 : rd_idx_q + IDX_W'(1);

	assign sts.dump = (used && (cnt_new >= CNT_W'(MAX_RUN)))
		|| (!used && (run_count_q != '0))
		|| ((bank_end || last_q) && (cnt_new != '0));
	assign sts.last     = last_q;
	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.data_end = (CNT_W'(rd_idx_q) + CNT_W'(1) == run_count_q);

	srif_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MAX_RUN)
	) u_run_buf (
		.clk  (clk),
		.we   (cmd.step && used),
		.waddr(run_count_q[IDX_W-1:0]),
		.wdata(data_q),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	// item capture, payload only, and the run buffer read index
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tag_q  <= map_tag;
			data_q <= data_byte;
			last_q <= last_item;
		end
		if (cmd.rd_en) begin
			rd_idx_q <= raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			run_count_q <= '0;
			run_start_q <= '0;
			bank_q      <= '0;
			offset_q    <= '0;
			first_tag_q <= '0;
			sum_q       <= '0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_data;
			end
			if (cmd.step) begin
				if ((bank_q == '0) && (offset_q == '0)) begin
					first_tag_q <= tag_q;
				end
				if (used && (run_count_q == '0)) begin
					run_start_q <= offset_q;
				end
				run_count_q <= cnt_new;
			end
			if (cmd.emit_hdr) begin
				sum_q <= hdr_sum;
			end else if (cmd.emit_data) begin
				sum_q <= sum_q + rdata;
			end
			if (cmd.clear_run) begin
				run_count_q <= '0;
			end
			if (cmd.advance) begin
				if (last_q) begin
					run_count_q <= '0;
					run_start_q <= '0;
					bank_q      <= '0;
					offset_q    <= '0;
				end else if (bank_end) begin
					offset_q <= '0;
					bank_q   <= (bank_q == BANK_W'(MAX_BANKS - 1)) ? '0 : bank_q + BANK_W'(1);
				end else begin
					offset_q <= offset_q + OFS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_hdr || cmd.emit_data || cmd.emit_chk || cmd.emit_trl) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_hdr) begin
			kind_q        <= KIND_HDR;
			value_q       <= hdr_count;
			address_q     <= hdr_addr;
			last_of_run_q <= 1'b0;
		end else if (cmd.emit_data) begin
			kind_q        <= KIND_DATA;
			value_q       <= rdata;
			address_q     <= '0;
			last_of_run_q <= 1'b0;
		end else if (cmd.emit_chk) begin
			kind_q        <= KIND_CHK;
			value_q       <= ~sum_q;
			address_q     <= '0;
			last_of_run_q <= !last_q;
		end else if (cmd.emit_trl) begin
			kind_q        <= KIND_TRL;
			value_q       <= ~trl_sum;
			address_q     <= trl_addr;
			last_of_run_q <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign value       = value_q;
	assign address     = address_q;
	assign last_of_run = last_of_run_q;

endmodule

### design/srif_ctrl.sv
`timescale 1ns / 1ps
`include "srecord_image_framer_macros.svh"
// ----------------------------------------------------------------------------
// srif_ctrl
// Framer sequencer: takes one item, updates the run, then walks a flushed
// run through header, data and checksum, and ends the final item with the trailer.
// ----------------------------------------------------------------------------
module srif_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output srif_pkg::srif_cmd_t  cmd,
	input  srif_pkg::srif_sts_t  sts
);
	import srif_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_HDR,
		ST_DATA,
		ST_CHK,
		ST_TRL
	} state_t;

	state_t state_q;
	state_t state_d;

	logic [3:0] emits;
	logic       emit_any;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_STEP;
				end
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				if (sts.dump) begin
					state_d = ST_HDR;
				end else if (sts.last) begin
					state_d = ST_TRL;
				end else begin
					cmd.advance = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_HDR: begin
				if (sts.out_free) begin
					cmd.emit_hdr = 1'b1;
					cmd.rd_en    = 1'b1;
					cmd.rd_first = 1'b1;
					state_d      = ST_DATA;
				end
			end
			ST_DATA: begin
				if (sts.out_free) begin
					cmd.emit_data = 1'b1;
					if (sts.data_end) begin
						state_d = ST_CHK;
					end else begin
						cmd.rd_en = 1'b1;
					end
				end
			end
			ST_CHK: begin
				if (sts.out_free) begin
					cmd.emit_chk  = 1'b1;
					cmd.clear_run = 1'b1;
					if (sts.last) begin
						state_d = ST_TRL;
					end else begin
						cmd.advance = 1'b1;
						state_d     = ST_IDLE;
					end
				end
			end
			ST_TRL: begin
				if (sts.out_free) begin
					cmd.emit_trl = 1'b1;
					cmd.advance  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	assign emits    = {cmd.emit_hdr, cmd.emit_data, cmd.emit_chk, cmd.emit_trl};
	assign emit_any = |emits;

	`SRIF_NEXT(a_capture_steps, cmd.capture, state_q == ST_STEP, "captured item not stepped")
	`SRIF_IMPLY(a_emit_free, emit_any, sts.out_free, "request emitted while output full")
	`SRIF_IMPLY(a_trailer_last, state_q == ST_TRL, sts.last, "trailer without a final item")
	`SRIF_CHECK(a_one_emit, $onehot0(emits), "two requests emitted at once")

endmodule

### design/srecord_image_framer.sv
`timescale 1ns / 1ps
// An item that causes no request passes through accept and run update.
// A flush walks through header, data and checksum, the final item also
// through the trailer; requests leave through the output register.
// During a flush the sequencer issues one request per cycle while not stalled.
// Reset clears counters, first tag and base address; the run buffer is not cleared.
// ----------------------------------------------------------------------------
// srecord_image_framer
// Frames a ROM image into S2 data records and an S8 trailer, binary fields.
// ----------------------------------------------------------------------------
module srecord_image_framer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [srif_pkg::ADDR_W-1:0]  base_address,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [srif_pkg::BYTE_W-1:0]  map_tag,
	input  logic [srif_pkg::BYTE_W-1:0]  data_byte,
	input  logic                         last_item,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   kind,
	output logic [srif_pkg::BYTE_W-1:0]  value,
	output logic [srif_pkg::ADDR_W-1:0]  address,
	output logic                         last_of_run
);
	import srif_pkg::*;

	srif_cmd_t cmd;
	srif_sts_t sts;

	assign cfg_ready = 1'b1;

	srif_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd     (cmd),
		.sts     (sts)
	);

	srif_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_data   (base_address),
		.cfg_we     (cfg_valid && cfg_ready),
		.map_tag    (map_tag),
		.data_byte  (data_byte),
		.last_item  (last_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.value      (value),
		.address    (address),
		.last_of_run(last_of_run)
	);

endmodule
